// File: design/lrast_pkg.sv
// Package for the line rasterizer: shared widths, register indexes and the
// structs that move between the front, the back and the result queue.
// Depends on nothing.
package lrast_pkg;

   // Widest coordinate the design supports and the step counter width.
   localparam int COORD_MAX_BITS = 16;
   localparam int STEP_BITS      = 7;

   // Payload widths fixed by the interface.
   localparam int ADDR_BITS   = 33;
   localparam int COLOUR_BITS = 32;
   localparam int BASE_BITS   = 32;
   localparam int PITCH_BITS  = 14;
   localparam int PROD_BITS   = COORD_MAX_BITS + PITCH_BITS;

   // Configuration port.
   localparam int CSR_INDEX_BITS = 4;
   localparam int CSR_DATA_BITS  = 32;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FRAME_BASE = 4'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_LINE_PITCH = 4'd1;
   localparam logic [PITCH_BITS-1:0]     PITCH_RESET    = 14'd1024;

   // Command queue between front and back.
   localparam int CMD_DEPTH    = 2;
   localparam int CMD_PTR_BITS = 1;
   localparam int CMD_CNT_BITS = 2;

   // Result queue.
   localparam int RSP_DEPTH    = 4;
   localparam int RSP_PTR_BITS = 2;
   localparam int RSP_CNT_BITS = 3;

   // Classified line command.
   typedef struct packed {
      logic [COORD_MAX_BITS-1:0] x0;
      logic [COORD_MAX_BITS-1:0] y0;
      logic                      xneg;
      logic                      yneg;
      logic                      xmajor;
      logic [STEP_BITS-1:0]      major;
      logic [STEP_BITS-1:0]      minor;
      logic [COLOUR_BITS-1:0]    colour;
      logic                      too_long;
   } cmd_type;

   // One pixel leaving the stepper.
   typedef struct packed {
      logic [COORD_MAX_BITS-1:0] x;
      logic [COORD_MAX_BITS-1:0] y;
      logic [COLOUR_BITS-1:0]    colour;
      logic                      last;
      logic                      too_long;
   } pix_type;

   // One result item.
   typedef struct packed {
      logic [ADDR_BITS-1:0]   addr;
      logic [COLOUR_BITS-1:0] colour;
      logic                   last;
      logic                   too_long;
   } rsp_type;

   // Configuration seen by the back end.
   typedef struct packed {
      logic [BASE_BITS-1:0]  base;
      logic [PITCH_BITS-1:0] pitch;
   } cfg_type;

endpackage

// File: design/lrast_front.sv
// Front end of the line rasterizer: accepts line commands, works out lengths,
// directions and the special cases, and holds them in a small command queue.
// Depends on lrast_pkg.
module lrast_front #(
   parameter int COORD_BITS = 12,
   parameter int MAX_STEPS  = 64
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_push,
   output logic                             req_full,
   input  logic [COORD_BITS-1:0]            req_start_x,
   input  logic [COORD_BITS-1:0]            req_start_y,
   input  logic [COORD_BITS-1:0]            req_end_x,
   input  logic [COORD_BITS-1:0]            req_end_y,
   input  logic [lrast_pkg::COLOUR_BITS-1:0] req_line_colour,
   output logic                             cmd_valid,
   output lrast_pkg::cmd_type               cmd_head,
   input  logic                             cmd_pop
);

   logic                  xneg;
   logic                  yneg;
   logic [COORD_BITS-1:0] dx;
   logic [COORD_BITS-1:0] dy;
   logic                  xmajor;
   logic [COORD_BITS-1:0] major_len;
   logic [COORD_BITS-1:0] minor_len;
   logic                  zero_len;
   lrast_pkg::cmd_type    cmd_new;

   lrast_pkg::cmd_type                      q_ff [lrast_pkg::CMD_DEPTH];
   logic [lrast_pkg::CMD_PTR_BITS-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [lrast_pkg::CMD_PTR_BITS-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [lrast_pkg::CMD_CNT_BITS-1:0]      count_ff, count_in;
   logic                                    do_push;
   logic                                    do_pop;

   // Lengths and directions of the incoming line.
   always_comb begin
      xneg      = req_end_x < req_start_x;
      yneg      = req_end_y < req_start_y;
      dx        = xneg ? req_start_x - req_end_x : req_end_x - req_start_x;
      dy        = yneg ? req_start_y - req_end_y : req_end_y - req_start_y;
      xmajor    = dx >= dy;
      major_len = xmajor ? dx : dy;
      minor_len = xmajor ? dy : dx;
      zero_len  = major_len == '0;
   end

   // Classified command. Lengths are only meaningful when the line is not too long.
   always_comb begin
      cmd_new          = '0;
      cmd_new.x0       = lrast_pkg::COORD_MAX_BITS'(req_start_x);
      cmd_new.y0       = lrast_pkg::COORD_MAX_BITS'(req_start_y);
      cmd_new.xneg     = xneg;
      cmd_new.yneg     = yneg;
      cmd_new.xmajor   = xmajor;
      cmd_new.major    = lrast_pkg::STEP_BITS'(major_len);
      cmd_new.minor    = lrast_pkg::STEP_BITS'(minor_len);
      cmd_new.colour   = req_line_colour;
      cmd_new.too_long = major_len > COORD_BITS'(MAX_STEPS);
   end

   // Queue control. A zero-length line is taken but never queued.
   assign req_full  = count_ff == lrast_pkg::CMD_CNT_BITS'(lrast_pkg::CMD_DEPTH);
   assign do_push   = req_push && !req_full && !zero_len;
   assign do_pop    = cmd_pop && (count_ff != '0);
   assign cmd_valid = count_ff != '0;
   assign cmd_head  = q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + lrast_pkg::CMD_CNT_BITS'(do_push)
                  - lrast_pkg::CMD_CNT_BITS'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Queue storage.
   always_ff @(posedge clock) begin
      if (do_push) begin
         q_ff[wr_ptr_ff] <= cmd_new;
      end
   end

endmodule

// File: design/lrast_rsp_fifo.sv
// Result queue of the line rasterizer: holds finished pixel writes until the
// consumer takes them. Depends on lrast_pkg.
module lrast_rsp_fifo (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 push,
   input  lrast_pkg::rsp_type                   push_data,
   input  logic                                 pop,
   output logic                                 empty,
   output lrast_pkg::rsp_type                   head,
   output logic [lrast_pkg::RSP_CNT_BITS-1:0]   level
);

   lrast_pkg::rsp_type                   mem_ff [lrast_pkg::RSP_DEPTH];
   logic [lrast_pkg::RSP_PTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [lrast_pkg::RSP_PTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [lrast_pkg::RSP_CNT_BITS-1:0]   count_ff, count_in;
   logic                                 do_pop;

   assign empty  = count_ff == '0;
   assign head   = mem_ff[rd_ptr_ff];
   assign level  = count_ff;
   assign do_pop = pop && !empty;

   // Pointer and level update.
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + lrast_pkg::RSP_CNT_BITS'(push)
                  - lrast_pkg::RSP_CNT_BITS'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage.
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

`ifndef SYNTH
   // The back end reserves room, so a write never lands on a full queue.
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (count_ff != lrast_pkg::RSP_CNT_BITS'(lrast_pkg::RSP_DEPTH)))
      else $error("result queue written while full");

   // The level never passes the depth.
   a_level_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= lrast_pkg::RSP_CNT_BITS'(lrast_pkg::RSP_DEPTH))
      else $error("result queue level out of range");

   // A lone transfer out lowers the level by one.
   a_pop_level: assert property (@(posedge clock) disable iff (reset)
      (do_pop && !push) |=> (count_ff == $past(count_ff) - 1'b1))
      else $error("result queue level wrong after transfer out");
`endif

endmodule

// File: design/lrast_back.sv
// Back end of the line rasterizer: steps along each queued line one pixel per
// cycle while the result queue has room, and forms the word address in a
// two-stage multiply and add pipeline. Depends on lrast_pkg.
module lrast_back (
   input  logic                                 clock,
   input  logic                                 reset,
   input  lrast_pkg::cfg_type                   cfg,
   input  logic                                 cmd_valid,
   input  lrast_pkg::cmd_type                   cmd_head,
   output logic                                 cmd_pop,
   input  logic [lrast_pkg::RSP_CNT_BITS-1:0]   rsp_level,
   output logic                                 rsp_push,
   output lrast_pkg::rsp_type                   rsp_data
);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_RUN  = 2'b10
   } state_type;

   state_type                               state_ff, state_in;
   lrast_pkg::cmd_type                      cur_ff, cur_in;
   logic [lrast_pkg::COORD_MAX_BITS-1:0]    px_ff, px_in;
   logic [lrast_pkg::COORD_MAX_BITS-1:0]    py_ff, py_in;
   logic [lrast_pkg::STEP_BITS-1:0]         acc_ff, acc_in;
   logic [lrast_pkg::STEP_BITS-1:0]         remain_ff, remain_in;
   logic [lrast_pkg::STEP_BITS-1:0]         acc_sum;
   logic                                    minor_step;
   logic                                    room;
   logic                                    emit;
   lrast_pkg::pix_type                      pix_in;

   logic                                    v0_ff;
   lrast_pkg::pix_type                      pix0_ff;
   logic                                    v1_ff;
   logic [lrast_pkg::PROD_BITS-1:0]         prod_ff;
   logic [lrast_pkg::ADDR_BITS-1:0]         basex_ff;
   logic [lrast_pkg::COLOUR_BITS-1:0]       colour1_ff;
   logic                                    last1_ff;
   logic                                    too_long1_ff;

   // Room in the result queue counting the pixels still in the pipeline.
   assign room = (rsp_level + lrast_pkg::RSP_CNT_BITS'(v0_ff)
                  + lrast_pkg::RSP_CNT_BITS'(v1_ff))
                 < lrast_pkg::RSP_CNT_BITS'(lrast_pkg::RSP_DEPTH);

   // Line stepper.
   always_comb begin
      state_in   = state_ff;
      cur_in     = cur_ff;
      px_in      = px_ff;
      py_in      = py_ff;
      acc_in     = acc_ff;
      remain_in  = remain_ff;
      cmd_pop    = 1'b0;
      emit       = 1'b0;
      pix_in     = '0;
      acc_sum    = acc_ff + cur_ff.minor;
      minor_step = acc_sum >= cur_ff.major;
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd_valid && (!cmd_head.too_long || room)) begin
               cmd_pop = 1'b1;
               if (cmd_head.too_long) begin
                  // Rejected line: one flagged result with zero address and colour.
                  emit            = 1'b1;
                  pix_in.last     = 1'b1;
                  pix_in.too_long = 1'b1;
               end else begin
                  cur_in    = cmd_head;
                  px_in     = cmd_head.x0;
                  py_in     = cmd_head.y0;
                  acc_in    = '0;
                  remain_in = cmd_head.major;
                  state_in  = ST_RUN;
               end
            end
         end
         ST_RUN: begin
            if (room) begin
               acc_in = minor_step ? acc_sum - cur_ff.major : acc_sum;
               if (cur_ff.xmajor || minor_step) begin
                  px_in = cur_ff.xneg ? px_ff - 1'b1 : px_ff + 1'b1;
               end
               if (!cur_ff.xmajor || minor_step) begin
                  py_in = cur_ff.yneg ? py_ff - 1'b1 : py_ff + 1'b1;
               end
               emit          = 1'b1;
               pix_in.x      = px_in;
               pix_in.y      = py_in;
               pix_in.colour = cur_ff.colour;
               pix_in.last   = remain_ff == lrast_pkg::STEP_BITS'(1);
               remain_in     = remain_ff - 1'b1;
               if (pix_in.last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         remain_ff <= '0;
         acc_ff    <= '0;
      end else begin
         state_ff  <= state_in;
         remain_ff <= remain_in;
         acc_ff    <= acc_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      px_ff  <= px_in;
      py_ff  <= py_in;
   end

   // Pipeline valid bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
      end else begin
         v0_ff <= emit;
         v1_ff <= v0_ff;
      end
   end

   // Stage zero holds the pixel; stage one holds the row product and base plus x.
   always_ff @(posedge clock) begin
      pix0_ff      <= pix_in;
      colour1_ff   <= pix0_ff.colour;
      last1_ff     <= pix0_ff.last;
      too_long1_ff <= pix0_ff.too_long;
      if (pix0_ff.too_long) begin
         prod_ff  <= '0;
         basex_ff <= '0;
      end else begin
         prod_ff  <= lrast_pkg::PROD_BITS'(pix0_ff.y) * lrast_pkg::PROD_BITS'(cfg.pitch);
         basex_ff <= lrast_pkg::ADDR_BITS'(cfg.base) + lrast_pkg::ADDR_BITS'(pix0_ff.x);
      end
   end

   // Final address add feeds the result queue.
   always_comb begin
      rsp_push          = v1_ff;
      rsp_data.addr     = basex_ff + lrast_pkg::ADDR_BITS'(prod_ff);
      rsp_data.colour   = colour1_ff;
      rsp_data.last     = last1_ff;
      rsp_data.too_long = too_long1_ff;
   end

`ifndef SYNTH
   // While stepping there is always at least one pixel left.
   a_run_remain: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN) |-> (remain_ff != '0))
      else $error("stepper running with no pixels left");

   // The error term stays below the major length.
   a_acc_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN) |-> (acc_ff < cur_ff.major))
      else $error("error accumulator out of range");

   // Queued and in-flight pixels never exceed the result queue depth.
   a_reserve: assert property (@(posedge clock) disable iff (reset)
      (rsp_level + lrast_pkg::RSP_CNT_BITS'(v0_ff) + lrast_pkg::RSP_CNT_BITS'(v1_ff))
      <= lrast_pkg::RSP_CNT_BITS'(lrast_pkg::RSP_DEPTH))
      else $error("result queue reservation exceeded");

   // A command is taken from the queue only when one is there.
   a_pop_valid: assert property (@(posedge clock) disable iff (reset)
      cmd_pop |-> cmd_valid)
      else $error("command taken from empty queue");
`endif

endmodule

// File: design/line_rasterizer.sv
// Line rasterizer: a line command becomes one pixel write per major-axis step.
// The back-end stepper gives one pixel per cycle while the result queue has
// room; a too-long line gives one flagged result, a zero-length line none.
// Reset clears all control state, sets frame_base to 0 and line_pitch to 1024.
// There is no clearing pass.
module line_rasterizer #(
   parameter int MAX_STEPS  = 64,
   parameter int COORD_BITS = 12
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  push,
   output logic                                  full,
   input  logic [COORD_BITS-1:0]                 req_start_x,
   input  logic [COORD_BITS-1:0]                 req_start_y,
   input  logic [COORD_BITS-1:0]                 req_end_x,
   input  logic [COORD_BITS-1:0]                 req_end_y,
   input  logic [lrast_pkg::COLOUR_BITS-1:0]     req_line_colour,
   output logic                                  empty,
   input  logic                                  pop,
   output logic [lrast_pkg::ADDR_BITS-1:0]       rsp_pixel_address,
   output logic [lrast_pkg::COLOUR_BITS-1:0]     rsp_pixel_colour,
   output logic                                  rsp_last_pixel,
   output logic                                  rsp_too_long,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [lrast_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [lrast_pkg::CSR_DATA_BITS-1:0]   csr_wdata
);

   logic [lrast_pkg::BASE_BITS-1:0]    base_ff;
   logic [lrast_pkg::PITCH_BITS-1:0]   pitch_ff;
   lrast_pkg::cfg_type                 cfg;
   logic                               cmd_valid;
   lrast_pkg::cmd_type                 cmd_head;
   logic                               cmd_pop;
   logic [lrast_pkg::RSP_CNT_BITS-1:0] rsp_level;
   logic                               rsp_push;
   lrast_pkg::rsp_type                 rsp_data;
   lrast_pkg::rsp_type                 rsp_head;

   // Configuration registers; writes are always taken.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff  <= '0;
         pitch_ff <= lrast_pkg::PITCH_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            lrast_pkg::CSR_FRAME_BASE: base_ff  <= csr_wdata;
            lrast_pkg::CSR_LINE_PITCH: pitch_ff <= csr_wdata[lrast_pkg::PITCH_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   assign cfg.base  = base_ff;
   assign cfg.pitch = pitch_ff;

   // Front end: classify and queue commands.
   lrast_front #(
      .COORD_BITS (COORD_BITS),
      .MAX_STEPS  (MAX_STEPS)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .req_push        (push),
      .req_full        (full),
      .req_start_x     (req_start_x),
      .req_start_y     (req_start_y),
      .req_end_x       (req_end_x),
      .req_end_y       (req_end_y),
      .req_line_colour (req_line_colour),
      .cmd_valid       (cmd_valid),
      .cmd_head        (cmd_head),
      .cmd_pop         (cmd_pop)
   );

   // Back end: step lines and form addresses.
   lrast_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .cmd_valid (cmd_valid),
      .cmd_head  (cmd_head),
      .cmd_pop   (cmd_pop),
      .rsp_level (rsp_level),
      .rsp_push  (rsp_push),
      .rsp_data  (rsp_data)
   );

   // Result queue toward the consumer.
   lrast_rsp_fifo u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (rsp_push),
      .push_data (rsp_data),
      .pop       (pop),
      .empty     (empty),
      .head      (rsp_head),
      .level     (rsp_level)
   );

   assign rsp_pixel_address = rsp_head.addr;
   assign rsp_pixel_colour  = rsp_head.colour;
   assign rsp_last_pixel    = rsp_head.last;
   assign rsp_too_long      = rsp_head.too_long;

endmodule
